@@ src/escaped_message_framer_defines.svh @@
// ----------------------------------------------------------------------------
// escaped message framer assertion macros
// shared property wrappers, clocked on clk and disabled during rst
// ----------------------------------------------------------------------------
`ifndef ESCAPED_MESSAGE_FRAMER_DEFINES_SVH
`define ESCAPED_MESSAGE_FRAMER_DEFINES_SVH

// same-cycle implication
`define EMF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define EMF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/emf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// emf_pkg
// shared constants and types of the escaped message framer
// ----------------------------------------------------------------------------
package emf_pkg;

  localparam logic [7:0] ESC_BYTE       = 8'd27;
  localparam logic [7:0] KIND_PULSE     = 8'd1;
  localparam logic [7:0] KIND_HEARTBEAT = 8'd2;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [2:0] SLOT_ESC   = 3'd0;
  localparam logic [2:0] SLOT_KIND  = 3'd1;
  localparam logic [2:0] SLOT_BYTE3 = 3'd2;
  localparam logic [2:0] SLOT_BYTE2 = 3'd3;
  localparam logic [2:0] SLOT_BYTE1 = 3'd4;
  localparam logic [2:0] SLOT_BYTE0 = 3'd5;

  typedef struct packed {
    logic [7:0]  kind_code;
    logic [31:0] payload;
    logic [3:0]  esc;
  } frame_entry_t;

  typedef struct packed {
    logic empty;
    logic full;
  } queue_status_t;

endpackage

@@ src/emf_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// emf_front
// accepts a message, picks its kind code and flags payload bytes to escape
// ----------------------------------------------------------------------------
module emf_front
  import emf_pkg::*;
(
  input  logic          start,
  input  logic          msg_kind,
  input  logic [31:0]   payload,
  input  queue_status_t q_status,
  output logic          busy,
  output logic          push,
  output frame_entry_t  entry
);

  assign busy = q_status.full;
  assign push = start && !q_status.full;

  always_comb begin
    entry.kind_code = msg_kind ? KIND_HEARTBEAT : KIND_PULSE;
    entry.payload   = payload;
    for (int i = 0; i < 4; i++) begin
      entry.esc[i] = (payload[8*i +: 8] == ESC_BYTE);
    end
  end

endmodule

@@ src/emf_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// emf_queue
// small fifo of classified messages between front and back
// ----------------------------------------------------------------------------
`include "escaped_message_framer_defines.svh"

module emf_queue
  import emf_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  frame_entry_t  wr_entry,
  input  logic          pop,
  output frame_entry_t  rd_entry,
  output queue_status_t status
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  frame_entry_t mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign status.empty = (count == '0);
  assign status.full  = (count == CNT_W'(DEPTH));
  assign rd_entry     = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  `EMF_ASSERT_NOW(a_no_pop_empty, pop, count != '0, "pop from empty queue")
  `EMF_ASSERT_NOW(a_no_push_full, push, count != CNT_W'(DEPTH), "push into full queue")
  `EMF_ASSERT_NEXT(a_count_step, push && !pop, count == $past(count) + CNT_W'(1), "count lost a push")

endmodule

@@ src/emf_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// emf_back
// serializes one queued message into its escaped byte frame, a beat a cycle
// ----------------------------------------------------------------------------
`include "escaped_message_framer_defines.svh"

module emf_back
  import emf_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  queue_status_t q_status,
  input  frame_entry_t  q_entry,
  output logic          pop,
  output logic [7:0]    out_byte,
  output logic          last,
  output logic          strobe
);

  frame_entry_t cur;
  logic         active;
  logic [2:0]   slot;
  logic         dup;

  logic [2:0]   slot_next;
  logic         dup_next;
  logic         active_next;
  logic         emit;
  logic [7:0]   byte_next;
  logic         last_next;
  logic [7:0]   data_byte;
  logic         data_esc;
  logic         finishing;

  always_comb begin
    case (slot)
      SLOT_ESC: begin
        data_byte = ESC_BYTE;
        data_esc  = 1'b0;
      end
      SLOT_BYTE3: begin
        data_byte = cur.payload[31:24];
        data_esc  = cur.esc[3];
      end
      SLOT_BYTE2: begin
        data_byte = cur.payload[23:16];
        data_esc  = cur.esc[2];
      end
      SLOT_BYTE1: begin
        data_byte = cur.payload[15:8];
        data_esc  = cur.esc[1];
      end
      SLOT_BYTE0: begin
        data_byte = cur.payload[7:0];
        data_esc  = cur.esc[0];
      end
      default: begin
        data_byte = cur.kind_code;
        data_esc  = 1'b0;
      end
    endcase
  end

  always_comb begin
    slot_next   = slot;
    dup_next    = dup;
    active_next = active;
    emit        = 1'b0;
    byte_next   = data_byte;
    last_next   = 1'b0;
    finishing   = 1'b0;
    if (active) begin
      emit = 1'b1;
      if (data_esc && !dup) begin
        byte_next = ESC_BYTE;
        dup_next  = 1'b1;
      end else begin
        dup_next  = 1'b0;
        slot_next = slot + 3'd1;
        if (slot == SLOT_BYTE0) begin
          last_next   = 1'b1;
          finishing   = 1'b1;
          active_next = 1'b0;
        end
      end
    end
    pop = (!active || finishing) && !q_status.empty;
    if (pop) begin
      active_next = 1'b1;
      dup_next    = 1'b0;
      if (active) begin
        // next frame opens right after this last beat
        slot_next = SLOT_ESC;
      end else begin
        emit      = 1'b1;
        byte_next = ESC_BYTE;
        last_next = 1'b0;
        slot_next = SLOT_KIND;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= q_entry;
    end
    if (emit) begin
      out_byte <= byte_next;
    end
    slot <= slot_next;
    dup  <= dup_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      strobe <= 1'b0;
      last   <= 1'b0;
    end else begin
      active <= active_next;
      strobe <= emit;
      last   <= last_next;
    end
  end

  `EMF_ASSERT_NOW(a_last_has_strobe, last, strobe, "last without strobe")
  `EMF_ASSERT_NEXT(a_frame_contiguous, strobe && !last, strobe, "gap inside a frame")
  `EMF_ASSERT_NOW(a_frame_opens_esc, strobe && !$past(strobe && !last), out_byte == ESC_BYTE, "frame does not open with escape byte")
  `EMF_ASSERT_NOW(a_active_emits, active, strobe || $past(pop), "active sequencer idle")

endmodule

@@ src/escaped_message_framer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// escaped_message_framer
// frames a kind and 32-bit value as an escaped byte stream
// ----------------------------------------------------------------------------
// usage:
//   input: drive msg_kind and payload with start high; the message is taken
//   at a rising edge where start is high and busy is low. busy is high while
//   the message queue is full.
//   output: one beat per cycle on out_byte with strobe high; last marks the
//   final byte. a frame is the escape byte 27, the kind code (1 pulse,
//   2 heartbeat), then the payload big-endian, a payload byte of 27 sent
//   twice. six to ten beats per frame.
//   first beat: with the serializer idle, an accepted message passes the
//   queue and the out_byte register before its first beat shows. frames
//   follow one another with no gap while the next message is queued.
//   throughput: the output serializer emits one byte a cycle within a frame;
//   the queue (QUEUE_DEPTH deep) lets messages arrive while one goes out.
//   reset: rst clears the queue and the serializer; no frame is in flight.
//   the receiver cannot stall: every strobed beat is taken in its cycle.
// ----------------------------------------------------------------------------
module escaped_message_framer
  import emf_pkg::*;
#(
  parameter int QDEPTH = QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        msg_kind,
  input  logic [31:0] payload,
  output logic [7:0]  out_byte,
  output logic        last,
  output logic        strobe
);

  queue_status_t q_status;
  frame_entry_t  wr_entry;
  frame_entry_t  rd_entry;
  logic          push;
  logic          pop;

  emf_front u_front (
    .start    (start),
    .msg_kind (msg_kind),
    .payload  (payload),
    .q_status (q_status),
    .busy     (busy),
    .push     (push),
    .entry    (wr_entry)
  );

  emf_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_entry (wr_entry),
    .pop      (pop),
    .rd_entry (rd_entry),
    .status   (q_status)
  );

  emf_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_status (q_status),
    .q_entry  (rd_entry),
    .pop      (pop),
    .out_byte (out_byte),
    .last     (last),
    .strobe   (strobe)
  );

endmodule
